### src/kwm_pkg.sv
`timescale 1ns / 1ps

package kwm_pkg;

  localparam int LANES   = 8;
  localparam int IDX_W   = $clog2(LANES);
  localparam int CNT_W   = $clog2(LANES + 1);
  localparam int CHILD_W = IDX_W + 2;
  localparam int LANE_W  = 3;
  localparam int KEY_W   = 32;
  localparam int CFG_W   = 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

  // Register index taken from the word address.
  localparam logic REG_ACTIVE_LANES = 1'b0;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_END  = 1'b1;

  typedef struct packed {
    logic                    mode;
    logic [LANE_W-1:0]       lane;
    logic signed [KEY_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LANE_W-1:0]       source_lane;
    logic                    done_res;
  } out_item_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LANE_W-1:0]       lane;
  } heap_entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    heap_entry_t       wdata;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic             restart;
    logic [LANES-1:0] active_mask;
  } cfg_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [LANES-1:0] awaiting;
  } status_t;

  // Smaller key first; equal keys are ordered by lane.
  function automatic logic ranks_before(heap_entry_t a, heap_entry_t b);
    logic res;
    if (a.key != b.key) begin
      res = (a.key < b.key);
    end else begin
      res = (a.lane < b.lane);
    end
    return res;
  endfunction

endpackage

### src/kwm_heap_ram.sv
`timescale 1ns / 1ps

module kwm_heap_ram (
  input  logic                clk,
  input  kwm_pkg::ram_req_t    req,
  output kwm_pkg::heap_entry_t rd_a,
  output kwm_pkg::heap_entry_t rd_b
);
  import kwm_pkg::*;

  heap_entry_t mem [LANES];
  heap_entry_t rd_a_r;
  heap_entry_t rd_b_r;

  // A read of the entry written in the same cycle returns the new data.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_a_r <= (req.we && (req.waddr == req.raddr_a)) ? req.wdata : mem[req.raddr_a];
    rd_b_r <= (req.we && (req.waddr == req.raddr_b)) ? req.wdata : mem[req.raddr_b];
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

endmodule

### src/kwm_cfg.sv
`timescale 1ns / 1ps

module kwm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kwm_pkg::PADDR_W-1:0]   paddr,
  input  logic [kwm_pkg::PDATA_W-1:0]   pwdata,
  output logic [kwm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output kwm_pkg::cfg_ctl_t             cfg
);
  import kwm_pkg::*;

  logic [CFG_W-1:0] active_r;
  logic [CFG_W-1:0] active_nxt;
  logic             wr_hit;
  logic [CNT_W-1:0] lanes_n;

  assign wr_hit = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_ACTIVE_LANES);

  always_comb begin
    active_nxt = active_r;
    if (wr_hit) begin
      active_nxt = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Zero lanes acts as one lane, and counts past the lane total saturate.
  always_comb begin
    if (active_r == '0) begin
      lanes_n = CNT_W'(1);
    end else if (32'(active_r) > LANES) begin
      lanes_n = CNT_W'(LANES);
    end else begin
      lanes_n = CNT_W'(active_r);
    end
  end

  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      cfg.active_mask[j] = (32'(j) < 32'(lanes_n));
    end
    cfg.restart = wr_hit;
  end

  assign prdata = (paddr[PADDR_W-1] == REG_ACTIVE_LANES) ? PDATA_W'(active_r) : '0;
  assign pready = 1'b1;

endmodule

### src/kwm_ctrl.sv
`timescale 1ns / 1ps

module kwm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kwm_pkg::cfg_ctl_t    cfg,
  input  logic                 start,
  input  kwm_pkg::in_item_t    in_data,
  output logic                 busy,
  output logic                 out_strobe,
  output kwm_pkg::out_item_t   out_data,
  output kwm_pkg::ram_req_t    ram_req,
  input  kwm_pkg::heap_entry_t rd_a,
  input  kwm_pkg::heap_entry_t rd_b,
  output kwm_pkg::status_t     status
);
  import kwm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_PLACE,
    S_POP,
    S_DOWN
  } state_t;

  state_t           state_r,      state_nxt;
  logic [CNT_W-1:0] count_r,      count_nxt;
  logic [LANES-1:0] awaiting_r,   awaiting_nxt;
  logic             pop_pend_r,   pop_pend_nxt;
  logic [IDX_W-1:0] idx_r,        idx_nxt;
  heap_entry_t      item_r,       item_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_data_r,   out_data_nxt;

  logic [LANES-1:0]   lane_onehot;
  logic [LANES-1:0]   await_left;
  logic               hit;
  logic               pop_due;
  logic [IDX_W-1:0]   parent_of_count;
  logic [IDX_W-1:0]   parent_idx;
  logic [CHILD_W-1:0] child_l;
  logic [CHILD_W-1:0] child_r;
  logic               l_ok;
  logic               r_ok;
  logic               take_l;
  logic               take_r;
  heap_entry_t        best;
  logic [IDX_W-1:0]   m_idx;

  assign lane_onehot     = LANES'(1) << in_data.lane;
  assign await_left      = awaiting_r & ~lane_onehot;
  assign hit             = |(lane_onehot & awaiting_r & cfg.active_mask);
  assign pop_due         = ((await_left & cfg.active_mask) == '0);
  assign parent_of_count = IDX_W'((count_r - CNT_W'(1)) >> 1);
  assign parent_idx      = (idx_r - IDX_W'(1)) >> 1;
  assign child_l         = (CHILD_W'(idx_r) << 1) + CHILD_W'(1);
  assign child_r         = child_l + CHILD_W'(1);
  assign l_ok            = child_l < CHILD_W'(count_r);
  assign r_ok            = child_r < CHILD_W'(count_r);

  // Pick the smallest of the sinking item and its children.
  always_comb begin
    take_l = 1'b0;
    take_r = 1'b0;
    best   = item_r;
    if (l_ok && ranks_before(rd_a, item_r)) begin
      take_l = 1'b1;
      best   = rd_a;
    end
    if (r_ok && ranks_before(rd_b, best)) begin
      take_l = 1'b0;
      take_r = 1'b1;
      best   = rd_b;
    end
    m_idx = take_r ? IDX_W'(child_r) : IDX_W'(child_l);
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    awaiting_nxt   = awaiting_r;
    pop_pend_nxt   = pop_pend_r;
    idx_nxt        = idx_r;
    item_nxt       = item_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    ram_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start && hit) begin
          awaiting_nxt = await_left;
          pop_pend_nxt = pop_due;
          if (in_data.mode == MODE_PUSH) begin
            item_nxt  = '{key: in_data.value, lane: in_data.lane};
            idx_nxt   = IDX_W'(count_r);
            count_nxt = count_r + CNT_W'(1);
            if (count_r == '0) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = '0;
              ram_req.wdata = '{key: in_data.value, lane: in_data.lane};
              if (pop_due) begin
                state_nxt = S_POP;
              end
            end else begin
              ram_req.raddr_a = parent_of_count;
              state_nxt       = S_UP;
            end
          end else if (pop_due) begin
            if (count_r != '0) begin
              ram_req.raddr_a = '0;
              ram_req.raddr_b = IDX_W'(count_r - CNT_W'(1));
              state_nxt       = S_POP;
            end else begin
              // Every lane is exhausted and the heap is empty: end marker.
              out_strobe_nxt = 1'b1;
              out_data_nxt   = '{key: '0, source_lane: '0, done_res: 1'b1};
            end
          end
        end
      end

      S_UP: begin
        ram_req.we = 1'b1;
        if (ranks_before(item_r, rd_a)) begin
          ram_req.waddr = idx_r;
          ram_req.wdata = rd_a;
          idx_nxt       = parent_idx;
          if (parent_idx == '0) begin
            state_nxt = S_PLACE;
          end else begin
            ram_req.raddr_a = (parent_idx - IDX_W'(1)) >> 1;
          end
        end else begin
          ram_req.waddr = idx_r;
          ram_req.wdata = item_r;
          if (pop_pend_r) begin
            ram_req.raddr_a = '0;
            ram_req.raddr_b = IDX_W'(count_r - CNT_W'(1));
            state_nxt       = S_POP;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_PLACE: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = item_r;
        if (pop_pend_r) begin
          ram_req.raddr_a = '0;
          ram_req.raddr_b = IDX_W'(count_r - CNT_W'(1));
          state_nxt       = S_POP;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_POP: begin
        out_strobe_nxt  = 1'b1;
        out_data_nxt    = '{key: rd_a.key, source_lane: rd_a.lane, done_res: 1'b0};
        awaiting_nxt    = awaiting_r | (LANES'(1) << rd_a.lane);
        count_nxt       = count_r - CNT_W'(1);
        item_nxt        = rd_b;
        idx_nxt         = '0;
        ram_req.raddr_a = IDX_W'(1);
        ram_req.raddr_b = IDX_W'(2);
        state_nxt       = S_DOWN;
      end

      S_DOWN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = best;
        if (take_l || take_r) begin
          idx_nxt         = m_idx;
          ram_req.raddr_a = IDX_W'((CHILD_W'(m_idx) << 1) + CHILD_W'(1));
          ram_req.raddr_b = IDX_W'((CHILD_W'(m_idx) << 1) + CHILD_W'(2));
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg.restart) begin
      state_nxt    = S_IDLE;
      count_nxt    = '0;
      awaiting_nxt = '1;
      pop_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      awaiting_r   <= '1;
      pop_pend_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      awaiting_r   <= awaiting_nxt;
      pop_pend_r   <= pop_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    idx_r      <= idx_nxt;
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = out_strobe_r;
  assign out_data        = out_data_r;
  assign status.count    = count_r;
  assign status.awaiting = awaiting_r;

endmodule

### src/kway_heap_merge.sv
`timescale 1ns / 1ps
// A request that completes a round pops the root (S_POP) after any sift up (S_UP, S_PLACE);
// busy stays high through the sift down (S_DOWN) and no request is taken; the heap memory's
// single write port serializes the sift, one tree level per cycle, up to three levels
// for an insert and a pop. The receiver cannot stall; each result is held for one cycle
// under out_strobe. Reset (synchronous, rst_n low) and any write of active_lanes empty the
// heap and make every lane await a request; reset sets active_lanes to 8.

module kway_heap_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  kwm_pkg::in_item_t             in_data,
  output logic                          busy,
  output logic                          out_strobe,
  output kwm_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kwm_pkg::PADDR_W-1:0]   paddr,
  input  logic [kwm_pkg::PDATA_W-1:0]   pwdata,
  output logic [kwm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import kwm_pkg::*;

  cfg_ctl_t    cfg;
  ram_req_t    ram_req;
  heap_entry_t rd_a;
  heap_entry_t rd_b;
  status_t     status;

  kwm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  kwm_heap_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  kwm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .start      (start),
    .in_data    (in_data),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .ram_req    (ram_req),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .status     (status)
  );

  // Each lane holds at most one key, so the heap never overfills.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(status.count) <= LANES)
    else $error("heap count exceeds lane total");

  // A popped lane must be waiting for its refill.
  a_pop_awaits: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.done_res) |-> status.awaiting[out_data.source_lane])
    else $error("popped lane not marked as awaiting");

  // The end marker only follows an emptied heap.
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.done_res) |-> (status.count == '0))
    else $error("end marker with keys left in heap");

  // A pop always runs through the sift down (S_DOWN) before the next result.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("results on consecutive cycles");

endmodule
